FILE: rtl/tlwm_pkg.sv
// ----------------------------------------------------------------------------
// tlwm_pkg: shared types and constants for the text line width measure
// Request/result payloads, the token that travels down the glyph cell chain,
// and character constants used by the byte decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tlwm_pkg;

  // Line width accumulator width (fixed by the result field).
  localparam int unsigned WIDTH_BITS = 20;
  // Default glyph table depth.
  localparam int unsigned GLYPH_ENTRIES_DEF = 512;
  // Cell index compare width, covers table depths up to 8192.
  localparam int unsigned IDX_W = 13;

  localparam int unsigned CODE_W  = 16;
  localparam int unsigned GWID_W  = 8;
  localparam int unsigned SLOT_W  = 9;
  localparam int unsigned COUNT_W = 10;

  // Request opcodes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TEXT  = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  // Character constants.
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_LEAD_LO  = 8'h80;
  localparam logic [7:0] CH_LEAD_END = 8'hA0;
  localparam logic [7:0] CH_LEAD2_LO = 8'hE0;

  typedef struct packed {
    logic                opcode;
    logic [SLOT_W-1:0]   entry_index;
    logic [CODE_W-1:0]   entry_code;
    logic [GWID_W-1:0]   entry_width;
    logic [7:0]          text_byte;
  } in_req_t;

  typedef struct packed {
    logic [WIDTH_BITS-1:0] max_line_width;
    logic                  saturated;
  } out_rsp_t;

  typedef enum logic [1:0] {
    TOK_WRITE,
    TOK_GLYPH,
    TOK_NEWLINE,
    TOK_FINISH
  } tok_kind_e;

  // Token handed from cell to cell every cycle while the chain advances.
  typedef struct packed {
    logic               vld;
    tok_kind_e          kind;
    logic [CODE_W-1:0]  code;   // write data or lookup code
    logic [GWID_W-1:0]  wid;    // write data or width found so far
    logic [SLOT_W-1:0]  idx;    // target slot of a write
    logic [COUNT_W-1:0] cnt;    // search limit of a lookup
    logic               hit;    // lookup already matched upstream
  } tok_t;

endpackage

`default_nettype wire

FILE: rtl/tlwm_cell.sv
// ----------------------------------------------------------------------------
// tlwm_cell: one glyph table slot of the search chain
// Holds one code/width pair, applies writes aimed at its slot and resolves
// lookups passing by (first match wins), then hands the token on.
// ----------------------------------------------------------------------------
`default_nettype none

module tlwm_cell import tlwm_pkg::*; #(
  parameter int unsigned CellIdx = 0
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic adv_i,
  input  wire tok_t tok_i,
  output tok_t      tok_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CellIdx);

  logic [CODE_W-1:0] code_q;
  logic [GWID_W-1:0] wid_q;
  tok_t              tok_d, tok_q;
  logic              code_hit, in_range, wr_hit, is_lookup;

  assign code_hit  = (tok_i.code == code_q);
  assign in_range  = (IDX_W'(tok_i.cnt) > MyIdx);
  assign wr_hit    = tok_i.vld && (tok_i.kind == TOK_WRITE) && (IDX_W'(tok_i.idx) == MyIdx);
  assign is_lookup = tok_i.vld && (tok_i.kind == TOK_GLYPH);

  always_comb begin
    tok_d = tok_i;
    if (is_lookup) begin
      if (CellIdx == 0) begin
        // slot 0 also supplies the miss width
        tok_d.wid = wid_q;
        tok_d.hit = code_hit && in_range;
      end else if (!tok_i.hit && code_hit && in_range) begin
        tok_d.wid = wid_q;
        tok_d.hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && wr_hit) begin
      code_q <= tok_i.code;
      wid_q  <= tok_i.wid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (adv_i) begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

FILE: rtl/tlwm_accum.sv
// ----------------------------------------------------------------------------
// tlwm_accum: line width accumulator and result register
// Adds glyph widths with saturation, tracks the widest line and emits the
// result when a string ends.
// ----------------------------------------------------------------------------
`default_nettype none

module tlwm_accum import tlwm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic adv_i,
  input  wire tok_t tok_i,
  input  wire logic out_ready_i,
  output logic      out_valid_o,
  output out_rsp_t  out_rsp_o
);

  localparam logic [WIDTH_BITS-1:0] WidthMax = '1;

  logic [WIDTH_BITS-1:0] line_q, line_d, widest_q, widest_d, closed;
  logic                  sat_q, sat_d;
  logic                  out_vld_q, out_vld_d;
  out_rsp_t              rsp_q, rsp_d;
  logic [WIDTH_BITS:0]   sum;
  logic                  take;

  assign take   = adv_i && tok_i.vld;
  assign sum    = {1'b0, line_q} + (WIDTH_BITS + 1)'(tok_i.wid);
  assign closed = (line_q > widest_q) ? line_q : widest_q;

  always_comb begin
    line_d    = line_q;
    widest_d  = widest_q;
    sat_d     = sat_q;
    rsp_d     = rsp_q;
    out_vld_d = out_vld_q && !out_ready_i;
    if (take) begin
      unique case (tok_i.kind)
        TOK_GLYPH: begin
          if (sum >= {1'b0, WidthMax}) begin
            line_d = WidthMax;
            sat_d  = 1'b1;
          end else begin
            line_d = sum[WIDTH_BITS-1:0];
          end
        end
        TOK_NEWLINE: begin
          widest_d = closed;
          line_d   = '0;
        end
        TOK_FINISH: begin
          rsp_d.max_line_width = closed;
          rsp_d.saturated      = sat_q;
          out_vld_d            = 1'b1;
          line_d               = '0;
          widest_d             = '0;
          sat_d                = 1'b0;
        end
        default: begin
          // table writes end here
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q    <= '0;
      widest_q  <= '0;
      sat_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      line_q    <= line_d;
      widest_q  <= widest_d;
      sat_q     <= sat_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = rsp_q;

endmodule

`default_nettype wire

FILE: rtl/text_line_width_measure.sv
// ----------------------------------------------------------------------------
// text_line_width_measure: pixel width of the widest line of a text string
// Glyph table writes and text bytes arrive on one request channel; the widest
// line width of each finished string leaves on the result channel.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (in_valid_i/in_ready_o/in_req_i): opcode 0 writes a
//    glyph slot, opcode 1 delivers one text byte. A zero byte (or a zero
//    trail byte) ends the string and produces one result.
//  - Result channel (out_valid_o/out_ready_i/out_rsp_o): widest line width
//    and saturation flag.
//  - Config port: cfg_we_i writes encoding_mode (index 0) or glyph_count
//    (index 1) in the same cycle; both are latched into each request as it
//    enters, so later writes never disturb requests already in flight.
//  - The glyph table is a chain of GlyphEntries cells. Requests other than
//    lead or dropped bytes become tokens that move one cell per cycle while
//    not stalled; writes land in their slot, lookups pick the first match.
//  - Throughput: one request per cycle while not stalled. A string end shows
//    up on out_valid_o once its token has passed every cell register of the
//    chain and then the result register.
//  - Stall: the whole chain holds while a result waits and out_ready_i is
//    low; in_ready_o drops for that time.
//  - Reset: clears line state, lead byte, config and the chain; table slots
//    are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module text_line_width_measure import tlwm_pkg::*; #(
  parameter int unsigned GlyphEntries = GLYPH_ENTRIES_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [COUNT_W-1:0] cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire in_req_t            in_req_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_rsp_t                out_rsp_o
);

  logic               adv, accept;
  logic               mode_q;
  logic [COUNT_W-1:0] count_q;
  logic               lead_pend_q, lead_pend_d;
  logic [7:0]         lead_val_q, lead_val_d;
  logic [7:0]         b;
  tok_t               ent;
  tok_t               chain [GlyphEntries+1];

  // chain moves whenever the result register is free or being drained
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;
  assign b          = in_req_i.text_byte;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:  mode_q  <= cfg_data_i[0];
        CFG_COUNT: count_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // byte decoder: builds the token entering the chain
  always_comb begin
    ent         = '0;
    ent.cnt     = count_q;
    lead_pend_d = lead_pend_q;
    lead_val_d  = lead_val_q;
    if (in_req_i.opcode == OP_WRITE) begin
      ent.vld  = 1'b1;
      ent.kind = TOK_WRITE;
      ent.code = in_req_i.entry_code;
      ent.wid  = in_req_i.entry_width;
      ent.idx  = in_req_i.entry_index;
    end else if (lead_pend_q) begin
      // byte after a lead is its trail, whatever the mode; zero ends string
      lead_pend_d = 1'b0;
      lead_val_d  = '0;
      ent.vld     = 1'b1;
      ent.kind    = (b == CH_NUL) ? TOK_FINISH : TOK_GLYPH;
      ent.code    = {lead_val_q, b};
    end else begin
      ent.code = {8'h00, b};
      priority if (b == CH_NUL) begin
        ent.vld  = 1'b1;
        ent.kind = TOK_FINISH;
      end else if (b == CH_NL) begin
        ent.vld  = 1'b1;
        ent.kind = TOK_NEWLINE;
      end else if (mode_q || ((b >= CH_PRINT_LO) && (b < CH_LEAD_LO))) begin
        ent.vld  = 1'b1;
        ent.kind = TOK_GLYPH;
      end else if (((b >= CH_LEAD_LO) && (b < CH_LEAD_END)) || (b >= CH_LEAD2_LO)) begin
        lead_pend_d = 1'b1;
        lead_val_d  = b;
      end else begin
        // other control bytes are dropped
      end
    end
    ent.vld = ent.vld && accept;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_pend_q <= 1'b0;
      lead_val_q  <= '0;
    end else if (accept) begin
      lead_pend_q <= lead_pend_d;
      lead_val_q  <= lead_val_d;
    end
  end

  assign chain[0] = ent;

  for (genvar gi = 0; gi < GlyphEntries; gi++) begin : g_cell
    tlwm_cell #(
      .CellIdx (gi)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .tok_i  (chain[gi]),
      .tok_o  (chain[gi+1])
    );
  end

  tlwm_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .tok_i       (chain[GlyphEntries]),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for text_line_width_measure
// Drives glyph table writes and text bytes through the request channel,
// predicts the widest line width of each finished string with a behavioral
// model kept in step with every accepted request, and checks each result.
// ----------------------------------------------------------------------------
module tb;
  import tlwm_pkg::*;

  localparam int unsigned GLYPH_ENTRIES = GLYPH_ENTRIES_DEF;
  // A string end passes every cell register and the result register first.
  localparam int unsigned DRAIN_CYCLES = GLYPH_ENTRIES + 64;
  localparam int unsigned HOLD_CYCLES = 2000;
  localparam int unsigned CYCLE_LIMIT = 800000;
  localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = '1;

  // encoding_mode values
  localparam logic MODE_DBCS = 1'b0;  // lead byte + trail byte pairs
  localparam logic MODE_SBCS = 1'b1;  // every byte on its own

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = CFG_MODE;
  logic [COUNT_W-1:0] cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  in_req_t            in_req_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_rsp_t           out_rsp_o;

  text_line_width_measure #(
    .GlyphEntries(GLYPH_ENTRIES)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  always #6 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Shared bookkeeping
  // --------------------------------------------------------------------------
  in_req_t  text_req_q[$];   // requests not yet offered to the block
  out_rsp_t widest_q[$];     // expected results of strings already closed
  out_rsp_t due_rsp;

  int unsigned cycle_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned idle_pct = 37;   // chance in 100 that a side idles this cycle

  // receiver hold-off: armed once by the stimulus, timed by its own counter
  logic        hold_arm = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  // Configuration as last written; used by prediction and by generation.
  logic               mode_q = MODE_DBCS;
  logic [COUNT_W-1:0] count_q = '0;

  // Glyph codes as planned by the generator (runs ahead of the block).
  logic [CODE_W-1:0] plan_code[GLYPH_ENTRIES];

  // --------------------------------------------------------------------------
  // Width predictor: string state and glyph table as the block should hold it
  // --------------------------------------------------------------------------
  logic [CODE_W-1:0]     glyph_code_tbl[GLYPH_ENTRIES];
  logic [GWID_W-1:0]     glyph_wid_tbl[GLYPH_ENTRIES];
  logic [WIDTH_BITS-1:0] cur_line = '0;
  logic [WIDTH_BITS-1:0] widest_line = '0;
  logic                  lead_pend = 1'b0;
  logic [7:0]            lead_val = '0;
  logic                  sat_seen = 1'b0;

  // Apply one accepted request; a string end queues its expected result.
  task automatic measure_request(input in_req_t req);
    logic [7:0]            c;
    logic [CODE_W-1:0]     code;
    logic                  look;
    logic                  hit;
    logic [GWID_W-1:0]     wid;
    logic [WIDTH_BITS:0]   sum;
    int unsigned           lim;
    out_rsp_t              rsp;
    c = req.text_byte;
    code = {8'h00, c};
    look = 1'b0;
    if (req.opcode == OP_WRITE) begin
      // table writes never touch the string state
      glyph_code_tbl[req.entry_index] = req.entry_code;
      glyph_wid_tbl[req.entry_index] = req.entry_width;
    end else if (c == CH_NUL) begin
      // zero byte ends the string, also when it arrives as a trail byte
      if (cur_line > widest_line) widest_line = cur_line;
      rsp.max_line_width = widest_line;
      rsp.saturated = sat_seen;
      widest_q.push_back(rsp);
      cur_line = '0;
      widest_line = '0;
      lead_pend = 1'b0;
      lead_val = '0;
      sat_seen = 1'b0;
    end else if (lead_pend) begin
      // pending lead takes this byte as trail, whatever the mode is now
      code = {lead_val, c};
      look = 1'b1;
      lead_pend = 1'b0;
      lead_val = '0;
    end else if (c == CH_NL) begin
      if (cur_line > widest_line) widest_line = cur_line;
      cur_line = '0;
    end else if (mode_q == MODE_SBCS || (c >= CH_PRINT_LO && c < CH_LEAD_LO)) begin
      look = 1'b1;
    end else if ((c >= CH_LEAD_LO && c < CH_LEAD_END) || c >= CH_LEAD2_LO) begin
      lead_pend = 1'b1;
      lead_val = c;
    end
    if (look) begin
      // first match among the searched entries, entry 0 on a miss
      lim = (count_q > GLYPH_ENTRIES) ? GLYPH_ENTRIES : count_q;
      wid = glyph_wid_tbl[0];
      hit = 1'b0;
      for (int i = 0; i < lim; i++) begin
        if (!hit && glyph_code_tbl[i] == code) begin
          wid = glyph_wid_tbl[i];
          hit = 1'b1;
        end
      end
      sum = {1'b0, cur_line} + wid;
      if (sum >= WIDTH_MAX) begin
        cur_line = WIDTH_MAX;
        sat_seen = 1'b1;
      end else begin
        cur_line = sum[WIDTH_BITS-1:0];
      end
    end
  endtask

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("MISMATCH cycle %0d: %s: got %0d, expected %0d", cycle_cnt, what, got, want);
    mismatch_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // Request driver: offers queued requests, predicts on each acceptance
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) measure_request(in_req_i);
      // payload may only change once the current request is gone
      if (!in_valid_i || in_ready_o) begin
        if (text_req_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid_i <= 1'b1;
          in_req_i <= text_req_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: compares each accepted result with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (widest_q.size() == 0) begin
          report("result with no string pending", out_rsp_o.max_line_width, 0);
        end else begin
          due_rsp = widest_q.pop_front();
          if (out_rsp_o.max_line_width !== due_rsp.max_line_width)
            report("max_line_width", out_rsp_o.max_line_width, due_rsp.max_line_width);
          if (out_rsp_o.saturated !== due_rsp.saturated)
            report("saturated", out_rsp_o.saturated, due_rsp.saturated);
        end
      end
      out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= idle_pct);
    end
  end

  // Long receiver hold-off so results back up into the chain and the input
  // channel stalls while the sender keeps offering.
  always @(posedge clk_i) begin
    if (hold_arm && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [7:0] pick_lead();
    if ($urandom_range(1) != 0) return 8'($urandom_range(CH_LEAD_END - 1, CH_LEAD_LO));
    return 8'($urandom_range(8'hFF, CH_LEAD2_LO));
  endfunction

  // Table codes lean toward what the text can actually hit.
  function automatic logic [CODE_W-1:0] new_code();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 4) return {8'h00, 8'($urandom_range(CH_LEAD_LO - 1, CH_PRINT_LO))};
    if (r < 8) return {pick_lead(), 8'($urandom)};
    return CODE_W'($urandom);
  endfunction

  task automatic push_write(input logic [SLOT_W-1:0] slot, input logic [CODE_W-1:0] code,
                            input logic [GWID_W-1:0] wid);
    in_req_t r;
    r.opcode = OP_WRITE;
    r.entry_index = slot;
    r.entry_code = code;
    r.entry_width = wid;
    r.text_byte = 8'($urandom);
    plan_code[slot] = code;
    text_req_q.push_back(r);
  endtask

  task automatic push_byte(input logic [7:0] b);
    in_req_t r;
    r.opcode = OP_TEXT;
    r.entry_index = SLOT_W'($urandom);
    r.entry_code = CODE_W'($urandom);
    r.entry_width = GWID_W'($urandom);
    r.text_byte = b;
    text_req_q.push_back(r);
  endtask

  // Mostly well-formed text with random content; some table rewrites, raw
  // noise bytes and broken lead/trail pairs mixed in.
  task automatic gen_text(input int unsigned n);
    int unsigned k;
    int unsigned r;
    int unsigned lim;
    logic [CODE_W-1:0] code;
    k = 0;
    while (k < n) begin
      r = $urandom_range(99);
      if (r < 6) begin
        push_write(SLOT_W'($urandom), new_code(), GWID_W'($urandom));
        k++;
      end else if (r < 11) begin
        push_byte(CH_NUL);
        k++;
      end else if (r < 18) begin
        push_byte(CH_NL);
        k++;
      end else if (r < 24) begin
        push_byte(8'($urandom));
        k++;
      end else begin
        if ($urandom_range(99) < 60) begin
          // a code that sits in the searched part of the table
          lim = (count_q > GLYPH_ENTRIES) ? GLYPH_ENTRIES : count_q;
          code = plan_code[(lim == 0) ? 0 : $urandom_range(lim - 1)];
        end else if ($urandom_range(1) != 0) begin
          code = {8'h00, 8'($urandom_range(CH_LEAD_LO - 1, CH_PRINT_LO))};
        end else begin
          code = {pick_lead(), 8'($urandom_range(255, 1))};
        end
        if (code[15:8] != 8'h00) begin
          push_byte(code[15:8]);
          k++;
        end
        push_byte(code[7:0]);
        k++;
      end
    end
  endtask

  // Register writes only go out while the block is idle.
  task automatic cfg_write(input logic idx, input logic [COUNT_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MODE) mode_q = data[0];
    else count_q = data;
  endtask

  // Wait for every request to go in and every result to come out, then let
  // table writes still walking the chain finish.
  task automatic settle();
    while (text_req_q.size() != 0 || in_valid_i || widest_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic mode, input logic [COUNT_W-1:0] count,
                           input int unsigned n);
    cfg_write(CFG_MODE, {{(COUNT_W-1){1'b0}}, mode});
    cfg_write(CFG_COUNT, count);
    gen_text(n);
    settle();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: double-byte mode, empty search so every lookup lands on
    // entry 0, the only entry that text can reach here.
    cfg_write(CFG_MODE, {{(COUNT_W-1){1'b0}}, MODE_DBCS});
    cfg_write(CFG_COUNT, '0);
    push_write(9'd0, 16'h0041, 8'd255);
    push_write(9'd511, 16'hFFFF, 8'd0);
    push_byte(CH_PRINT_LO);          // lowest single glyph
    push_byte(8'h7F);                // highest single glyph
    push_byte(8'h1F);                // control byte, skipped
    push_byte(CH_LEAD_END);          // 0xA0..0xDF skipped in this mode
    push_byte(8'hDF);
    push_byte(CH_NL);
    push_byte(CH_LEAD_LO);           // lead + trail, misses to entry 0
    push_byte(8'h01);
    push_byte(CH_NUL);               // ends string, widest of two lines
    push_byte(CH_NUL);               // empty string
    push_byte(8'h9F);                // lead followed by zero trail
    push_byte(CH_NUL);
    push_byte(CH_LEAD2_LO);
    push_byte(8'hFF);
    push_byte(CH_NL);
    push_byte(CH_NL);                // empty line
    push_byte(8'hFF);                // newline taken as a trail byte
    push_byte(CH_NL);
    push_byte(CH_NUL);
    push_byte(8'h41);
    push_byte(8'h85);                // lead left pending across a mode change
    settle();

    // Single-byte mode, full table filled with no idling on either side.
    // The first text byte completes the pending lead from before.
    idle_pct = 0;
    cfg_write(CFG_MODE, {{(COUNT_W-1){1'b0}}, MODE_SBCS});
    cfg_write(CFG_COUNT, COUNT_W'(GLYPH_ENTRIES));
    for (int i = 0; i < GLYPH_ENTRIES; i++)
      push_write(SLOT_W'(i), new_code(), GWID_W'($urandom));
    push_byte(8'h42);
    gen_text(120);
    settle();

    // Oversized search count, with the receiver holding off for a long while.
    idle_pct = 37;
    hold_arm = 1'b1;
    run_phase(MODE_DBCS, '1, 200);

    run_phase(MODE_DBCS, 10'd1, 90);
    run_phase(MODE_SBCS, 10'd0, 90);
    run_phase(MODE_DBCS, COUNT_W'($urandom_range(GLYPH_ENTRIES - 1, 2)), 90);
    run_phase(MODE_SBCS, COUNT_W'($urandom_range(GLYPH_ENTRIES - 1, 2)), 90);
    run_phase(MODE_DBCS, COUNT_W'(GLYPH_ENTRIES), 90);

    // One long line of full-width glyphs: every glyph is 255 wide.
    cfg_write(CFG_MODE, {{(COUNT_W-1){1'b0}}, MODE_DBCS});
    cfg_write(CFG_COUNT, '0);
    push_write(9'd0, 16'h0041, 8'd255);
    repeat (40) push_byte(8'($urandom_range(CH_LEAD_LO - 1, CH_PRINT_LO)));
    push_byte(CH_NL);
    push_byte(8'h41);
    push_byte(CH_NUL);
    push_byte(8'h41);                // next string starts clean
    push_byte(CH_NUL);
    settle();

    run_phase(MODE_SBCS, COUNT_W'($urandom_range(1023)), 90);

    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tlwm_pkg.sv
rtl/tlwm_cell.sv
rtl/tlwm_accum.sv
rtl/text_line_width_measure.sv
sim/tb.sv
